[hw/rtl/hots_pkg.sv]
// shared types and constants for the html open tag scanner
// request payload structs, result codes and byte constants; no dependencies

package hots_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] span_kind;
    logic [7:0] span_start;
    logic [7:0] span_len;
    logic [7:0] attr_name_start;
    logic [7:0] attr_name_len;
    logic [1:0] outcome;
    logic [7:0] tag_len_total;
  } out_item_t;

  // span kinds
  localparam logic [1:0] SpanNone = 2'd0;
  localparam logic [1:0] SpanTag  = 2'd1;
  localparam logic [1:0] SpanAttr = 2'd2;

  // outcomes
  localparam logic [1:0] OutPending = 2'd0;
  localparam logic [1:0] OutOpen    = 2'd1;
  localparam logic [1:0] OutSelfCl  = 2'd2;
  localparam logic [1:0] OutReject  = 2'd3;

  // bytes with a meaning of their own
  localparam logic [7:0] CharGt     = 8'h3E;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharDq     = 8'h22;
  localparam logic [7:0] CharSq     = 8'h27;
  localparam logic [7:0] CharUs     = 8'h5F;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharB      = 8'h62;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] NameHiBase = 8'h80;

  // br tracker codes
  localparam logic [1:0] BrFresh = 2'd0;
  localparam logic [1:0] BrB     = 2'd1;
  localparam logic [1:0] BrBr    = 2'd2;
  localparam logic [1:0] BrNone  = 2'd3;

endpackage

[hw/rtl/hots_scan.sv]
// scan state and per-byte next-state logic of the html open tag scanner
// depends on hots_pkg; state advances once per accepted request

module hots_scan #(
  parameter int unsigned MAX_TAG_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  hots_pkg::in_item_t item_i,
  output hots_pkg::out_item_t result_o
);
  import hots_pkg::*;

  localparam int unsigned TagLimit = (MAX_TAG_BYTES < 255) ? MAX_TAG_BYTES : 255;
  localparam logic [8:0] LimitW = 9'(TagLimit);

  typedef enum logic [3:0] {
    PhIdle, PhWaitTag, PhTag, PhWaitName, PhName,
    PhWaitEq, PhWaitVal, PhVal, PhQuote, PhSlash
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       quote_sq_q, quote_sq_d;
  logic [7:0] offset_q, offset_d;
  logic [7:0] span_q, span_d;
  logic [7:0] hname_start_q, hname_start_d;
  logic [7:0] hname_len_q, hname_len_d;
  logic       tag_seen_q, tag_seen_d;
  logic [1:0] br_q, br_d;

  function automatic logic is_name_byte(input logic [7:0] c);
    return (c > NameHiBase) ||
           (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CharUs, CharDash});
  endfunction

  logic [8:0] off_ext;
  logic [7:0] off;
  logic [7:0] seg_len;
  logic       do_reject, do_finish, fin_slash, do_close, go_slash, active;
  logic [7:0] ch;

  assign off_ext = {1'b0, offset_q} + 9'd1;
  assign off     = off_ext[7:0];
  assign seg_len = off - span_q;
  assign ch      = item_i.ch;
  assign active  = item_i.first || (phase_q != PhIdle);

  always_comb begin
    phase_d       = phase_q;
    quote_sq_d    = quote_sq_q;
    offset_d      = offset_q;
    span_d        = span_q;
    hname_start_d = hname_start_q;
    hname_len_d   = hname_len_q;
    tag_seen_d    = tag_seen_q;
    br_d          = br_q;
    result_o      = '0;
    do_reject     = 1'b0;
    do_finish     = 1'b0;
    fin_slash     = 1'b0;
    do_close      = 1'b0;
    go_slash      = 1'b0;

    if (item_i.first) begin
      phase_d       = PhWaitTag;
      quote_sq_d    = 1'b0;
      offset_d      = '0;
      span_d        = '0;
      hname_start_d = '0;
      hname_len_d   = '0;
      tag_seen_d    = 1'b0;
      br_d          = BrFresh;
      do_reject     = item_i.last;
    end else if (phase_q != PhIdle) begin
      if (off_ext >= LimitW) begin
        do_reject = 1'b1;
      end else begin
        offset_d = off;
        case (phase_q)
          PhQuote: begin
            if (ch == (quote_sq_q ? CharSq : CharDq)) begin
              result_o.span_kind       = SpanAttr;
              result_o.span_start      = span_q;
              result_o.span_len        = seg_len;
              result_o.attr_name_start = hname_start_q;
              result_o.attr_name_len   = hname_len_q;
              phase_d                  = PhWaitName;
            end
          end
          PhSlash: begin
            if (ch == CharGt) begin
              do_finish = 1'b1;
              fin_slash = 1'b1;
            end else begin
              do_reject = 1'b1;
            end
          end
          default: begin
            if (ch == CharGt) begin
              do_close  = 1'b1;
              do_finish = 1'b1;
            end else if (ch == CharSlash) begin
              do_close = 1'b1;
              go_slash = 1'b1;
            end else if (ch == CharSpace) begin
              do_close = 1'b1;
            end else if (ch == CharEq) begin
              if (phase_q == PhName) begin
                hname_start_d = span_q;
                hname_len_d   = seg_len;
                phase_d       = PhWaitVal;
              end else if (phase_q == PhWaitEq) begin
                phase_d = PhWaitVal;
              end else begin
                do_reject = 1'b1;
              end
            end else if (ch == CharDq || ch == CharSq) begin
              if (phase_q == PhWaitVal) begin
                quote_sq_d = (ch == CharSq);
                span_d     = off + 8'd1;
                phase_d    = PhQuote;
              end else begin
                do_reject = 1'b1;
              end
            end else if (is_name_byte(ch)) begin
              case (phase_q)
                PhWaitTag: begin
                  span_d  = off;
                  br_d    = (ch == CharB) ? BrB : BrNone;
                  phase_d = PhTag;
                end
                PhTag: begin
                  br_d = (br_q == BrB && ch == CharR) ? BrBr : BrNone;
                end
                PhWaitName, PhWaitEq: begin
                  span_d  = off;
                  phase_d = PhName;
                end
                PhWaitVal: begin
                  span_d  = off;
                  phase_d = PhVal;
                end
                default: ;
              endcase
            end else begin
              do_reject = 1'b1;
            end

            // the token ending just before this byte
            if (do_close) begin
              case (phase_q)
                PhTag: begin
                  result_o.span_kind  = SpanTag;
                  result_o.span_start = span_q;
                  result_o.span_len   = seg_len;
                  tag_seen_d          = 1'b1;
                  phase_d             = PhWaitName;
                end
                PhName: begin
                  hname_start_d = span_q;
                  hname_len_d   = seg_len;
                  phase_d       = PhWaitEq;
                end
                PhVal: begin
                  result_o.span_kind       = SpanAttr;
                  result_o.span_start      = span_q;
                  result_o.span_len        = seg_len;
                  result_o.attr_name_start = hname_start_q;
                  result_o.attr_name_len   = hname_len_q;
                  phase_d                  = PhWaitName;
                end
                default: ;
              endcase
            end
            if (go_slash) begin
              phase_d = PhSlash;
            end
          end
        endcase
      end
    end

    if (do_finish) begin
      if (!tag_seen_d) begin
        do_reject = 1'b1;
      end else begin
        result_o.outcome       = (fin_slash || br_q == BrBr) ? OutSelfCl : OutOpen;
        result_o.tag_len_total = off + 8'd1;
        phase_d                = PhIdle;
      end
    end

    // text ran out before the tag closed
    if (active && item_i.last && result_o.outcome == OutPending) begin
      do_reject = 1'b1;
    end

    if (do_reject) begin
      result_o         = '0;
      result_o.outcome = OutReject;
      phase_d          = PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      quote_sq_q    <= 1'b0;
      offset_q      <= '0;
      span_q        <= '0;
      hname_start_q <= '0;
      hname_len_q   <= '0;
      tag_seen_q    <= 1'b0;
      br_q          <= BrFresh;
    end else if (take_i) begin
      phase_q       <= phase_d;
      quote_sq_q    <= quote_sq_d;
      offset_q      <= offset_d;
      span_q        <= span_d;
      hname_start_q <= hname_start_d;
      hname_len_q   <= hname_len_d;
      tag_seen_q    <= tag_seen_d;
      br_q          <= br_d;
    end
  end

endmodule

[hw/rtl/html_open_tag_scanner.sv]
// top level of the html open tag scanner: request handshakes and result buffer
// depends on hots_pkg and hots_scan

// The scanner takes the bytes of one HTML open tag, one byte per request,
// starting at the '<' byte (marked with first) and reports one result per
// byte: the tag name span when it ends, each name=value attribute as a name
// span plus a value span, and the final outcome (open, self-closing from
// '/>' or a tag named exactly "br", or rejected). Offsets count from the '<'
// byte; a tag longer than the smaller of MAX_TAG_BYTES and 255 bytes is
// rejected. Throughput is one byte per cycle while in_stall_o is low: each
// byte updates the small scan state, and the result lands in an output
// register backed by one skid entry, so a new byte is taken while one
// finished result still waits downstream. in_stall_o rises only when both
// result entries are full.

module html_open_tag_scanner #(
  parameter int unsigned MAX_TAG_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte requests
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hots_pkg::in_item_t  in_item_i,
  // result requests
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hots_pkg::out_item_t out_item_o
);
  import hots_pkg::*;

  out_item_t result;
  out_item_t out_q;
  out_item_t skid_q;
  logic      out_valid_q;
  logic      skid_valid_q;
  logic      take;
  logic      out_free;

  // a byte is taken whenever the skid entry is empty
  assign take     = in_valid_i && !skid_valid_q;
  // output register can load this cycle when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  hots_scan #(
    .MAX_TAG_BYTES(MAX_TAG_BYTES)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (in_item_i),
    .result_o (result)
  );

  // valid flags of the two result entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      // skid entry, if any, moves up; otherwise the output drains
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  // result payloads, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (out_free) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end else if (out_free && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
